// ----- design/mlfq_pkg.sv -----
// Shared types and constants of the multilevel feedback task scheduler.
`default_nettype none

package mlfq_pkg;

  localparam int ID_W   = 4;
  localparam int TIME_W = 32;
  localparam int SLICE_W = 16;
  localparam int TICK_W  = 10;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int NUM_LEVELS_DEF = 3;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd500;
  localparam logic [TICK_W-1:0]  TICK_RESET  = 10'd1;

  // APB register file: slice (16 bits) at byte address 0 and tick (10 bits) at 4, on a 32-bit bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_SLICE = 1'b0;
  localparam logic REG_TICK  = 1'b1;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_RD,
    ST_ADD,
    ST_CMP,
    ST_DIFF,
    ST_SLICE,
    ST_DISP,
    ST_LOAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] burst_ms;
    logic [TIME_W-1:0] now_ms;
  } mlfq_in_t;

  typedef struct packed {
    logic              done_valid;
    logic [ID_W-1:0]   done_task;
    logic [TIME_W-1:0] done_time_ms;
    logic              demoted;
    logic              dispatched;
    logic              running_valid;
    logic [ID_W-1:0]   running_task;
    logic              dropped;
  } mlfq_out_t;

endpackage

`default_nettype wire

// ----- design/multilevel_feedback_task_scheduler_core.sv -----
// Top level of the multilevel feedback task scheduler.
//
// Task ids wait in NUM_LEVELS FIFO levels (level 0 first); each task has a
// burst and an elapsed-time entry. An arrival item stores the burst, clears
// elapsed and queues the id in level 0, or is flagged dropped when level 0 is
// full or the id is out of range. A tick item charges tick_length_ms to the
// running task (saturating), reports completion when elapsed reaches the
// burst, otherwise demotes it to the lowest level once now_ms - slice start
// (mod 2^32) reaches the slice register and that level has room, and then
// dispatches the head of the highest non-empty level if the processor is free.
// Exactly one result item per input item. One item is worked at a time:
// in_stall_o is high from acceptance until the result is taken. The time
// arithmetic runs through one shared 33-bit adder under a small sequencer,
// and each table is a memory with one write port and one registered read
// port. An arrival updates the tables and level 0 directly; a tick steps, as
// needed, through table read, add, burst compare, time difference, slice
// compare, level pick and FIFO read, and the result is held while out_stall_i
// is high. The memories need no clearing pass after reset.
`default_nettype none

module multilevel_feedback_task_scheduler_core #(
  parameter int MAX_TASKS  = mlfq_pkg::MAX_TASKS_DEF,
  parameter int NUM_LEVELS = mlfq_pkg::NUM_LEVELS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // item input
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire mlfq_pkg::mlfq_in_t        in_data_i,
  // result output
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output mlfq_pkg::mlfq_out_t            out_data_o,
  // APB configuration
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mlfq_pkg::APB_AW-1:0] paddr,
  input  wire logic [mlfq_pkg::APB_DW-1:0] pwdata,
  output logic [mlfq_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  localparam int PTR_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W    = $clog2(MAX_TASKS + 1);
  localparam int LVL_W    = $clog2(NUM_LEVELS);
  localparam int FA_W     = $clog2(NUM_LEVELS * MAX_TASKS);
  localparam int FDEPTH   = NUM_LEVELS * MAX_TASKS;
  localparam int LAST_LVL = NUM_LEVELS - 1;
  localparam int ID_W     = mlfq_pkg::ID_W;
  localparam int TIME_W   = mlfq_pkg::TIME_W;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (int'(p) == MAX_TASKS - 1) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [mlfq_pkg::SLICE_W-1:0] slice_q;
  logic [mlfq_pkg::TICK_W-1:0]  tick_q;
  logic                         cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mlfq_pkg::REG_TICK) ? mlfq_pkg::APB_DW'(tick_q)
                                                   : mlfq_pkg::APB_DW'(slice_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= mlfq_pkg::SLICE_RESET;
      tick_q  <= mlfq_pkg::TICK_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == mlfq_pkg::REG_TICK) begin
        tick_q <= pwdata[mlfq_pkg::TICK_W-1:0];
      end else begin
        slice_q <= pwdata[mlfq_pkg::SLICE_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  mlfq_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]  head_q [NUM_LEVELS];
  logic [PTR_W-1:0]  head_d [NUM_LEVELS];
  logic [PTR_W-1:0]  tail_q [NUM_LEVELS];
  logic [PTR_W-1:0]  tail_d [NUM_LEVELS];
  logic [CNT_W-1:0]  cnt_q  [NUM_LEVELS];
  logic [CNT_W-1:0]  cnt_d  [NUM_LEVELS];

  logic              cur_valid_q, cur_valid_d;
  logic [ID_W-1:0]   cur_task_q, cur_task_d;
  logic [TIME_W-1:0] slice_start_q, slice_start_d;

  // payload registers
  mlfq_pkg::mlfq_in_t  in_q;
  mlfq_pkg::mlfq_out_t res_q, res_d;
  logic [TIME_W-1:0]   acc_q, acc_d;

  // memories: level FIFO store, burst and elapsed tables
  logic [ID_W-1:0]   fifo_mem   [FDEPTH];
  logic [TIME_W-1:0] burst_mem  [MAX_TASKS];
  logic [TIME_W-1:0] elaps_mem  [MAX_TASKS];

  logic              fifo_we;
  logic [FA_W-1:0]   fifo_waddr, fifo_raddr;
  logic [ID_W-1:0]   fifo_rd_q;
  logic              burst_we;
  logic              elaps_we;
  logic [PTR_W-1:0]  elaps_waddr;
  logic [TIME_W-1:0] elaps_wdata;
  logic [TIME_W-1:0] burst_rd_q, elaps_rd_q;
  logic [PTR_W-1:0]  cur_addr;

  assign cur_addr = PTR_W'(cur_task_q);

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= cur_valid_q && (state_q == mlfq_pkg::ST_SLICE)
                              ? cur_task_q : in_q.task_id;
    end
    fifo_rd_q <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (burst_we) begin
      burst_mem[PTR_W'(in_q.task_id)] <= in_q.burst_ms;
    end
    burst_rd_q <= burst_mem[cur_addr];
  end

  always_ff @(posedge clk_i) begin
    if (elaps_we) begin
      elaps_mem[elaps_waddr] <= elaps_wdata;
    end
    elaps_rd_q <= elaps_mem[cur_addr];
  end

  // ---------------------------------------------------------------------
  // Shared adder: sum = a + b + cin, carry out doubles as unsigned a >= b'
  // when b is the inverted operand and cin is set.
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] alu_a, alu_b;
  logic              alu_cin;
  logic [TIME_W:0]   alu_res;

  assign alu_res = {1'b0, alu_a} + {1'b0, alu_b} + (TIME_W + 1)'(alu_cin);

  // highest-priority non-empty level
  logic             lvl_found;
  logic [LVL_W-1:0] sel_lvl;

  always_comb begin
    lvl_found = 1'b0;
    sel_lvl   = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        lvl_found = 1'b1;
        sel_lvl   = LVL_W'(l);
      end
    end
  end

  assign fifo_raddr = FA_W'(int'(sel_lvl) * MAX_TASKS + int'(head_q[sel_lvl]));

  logic in_acc;
  logic id_ok;
  logic full0, full_last;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign id_ok     = 32'(in_q.task_id) < 32'(MAX_TASKS);
  assign full0     = cnt_q[0] == CNT_W'(MAX_TASKS);
  assign full_last = cnt_q[LAST_LVL] == CNT_W'(MAX_TASKS);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    cnt_d         = cnt_q;
    cur_valid_d   = cur_valid_q;
    cur_task_d    = cur_task_q;
    slice_start_d = slice_start_q;
    res_d         = res_q;
    acc_d         = acc_q;
    fifo_we       = 1'b0;
    fifo_waddr    = FA_W'(tail_q[0]);
    burst_we      = 1'b0;
    elaps_we      = 1'b0;
    elaps_waddr   = PTR_W'(in_q.task_id);
    elaps_wdata   = '0;
    alu_a         = acc_q;
    alu_b         = ~in_q.now_ms;
    alu_cin       = 1'b1;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;

    case (state_q)
      mlfq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        // stall is low here, so valid alone means the item is taken
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.command == mlfq_pkg::CMD_ARRIVAL) begin
            state_d = mlfq_pkg::ST_ARRIVE;
          end else if (cur_valid_q) begin
            state_d = mlfq_pkg::ST_RD;
          end else begin
            state_d = mlfq_pkg::ST_DISP;
          end
        end
      end
      mlfq_pkg::ST_ARRIVE: begin
        if (id_ok && !full0) begin
          fifo_we     = 1'b1;
          burst_we    = 1'b1;
          elaps_we    = 1'b1;
          tail_d[0]   = ptr_next(tail_q[0]);
          cnt_d[0]    = cnt_q[0] + 1'b1;
        end else begin
          res_d.dropped = 1'b1;
        end
        state_d = mlfq_pkg::ST_OUT;
      end
      mlfq_pkg::ST_RD: begin
        // table reads at the running task's address land at the edge
        state_d = mlfq_pkg::ST_ADD;
      end
      mlfq_pkg::ST_ADD: begin
        alu_a       = elaps_rd_q;
        alu_b       = TIME_W'(tick_q);
        alu_cin     = 1'b0;
        acc_d       = alu_res[TIME_W] ? '1 : alu_res[TIME_W-1:0];
        elaps_we    = 1'b1;
        elaps_waddr = cur_addr;
        elaps_wdata = acc_d;
        state_d     = mlfq_pkg::ST_CMP;
      end
      mlfq_pkg::ST_CMP: begin
        alu_a = acc_q;
        alu_b = ~burst_rd_q;
        if (alu_res[TIME_W]) begin
          res_d.done_valid   = 1'b1;
          res_d.done_task    = cur_task_q;
          res_d.done_time_ms = in_q.now_ms;
          cur_valid_d        = 1'b0;
          state_d            = mlfq_pkg::ST_DISP;
        end else begin
          state_d = mlfq_pkg::ST_DIFF;
        end
      end
      mlfq_pkg::ST_DIFF: begin
        alu_a   = in_q.now_ms;
        alu_b   = ~slice_start_q;
        acc_d   = alu_res[TIME_W-1:0];
        state_d = mlfq_pkg::ST_SLICE;
      end
      mlfq_pkg::ST_SLICE: begin
        alu_a = acc_q;
        alu_b = ~TIME_W'(slice_q);
        if (alu_res[TIME_W] && !full_last) begin
          fifo_we          = 1'b1;
          fifo_waddr       = FA_W'(LAST_LVL * MAX_TASKS + int'(tail_q[LAST_LVL]));
          tail_d[LAST_LVL] = ptr_next(tail_q[LAST_LVL]);
          cnt_d[LAST_LVL]  = cnt_q[LAST_LVL] + 1'b1;
          res_d.demoted    = 1'b1;
          cur_valid_d      = 1'b0;
        end
        state_d = mlfq_pkg::ST_DISP;
      end
      mlfq_pkg::ST_DISP: begin
        if (!cur_valid_q && lvl_found) begin
          head_d[sel_lvl] = ptr_next(head_q[sel_lvl]);
          cnt_d[sel_lvl]  = cnt_q[sel_lvl] - 1'b1;
          slice_start_d   = in_q.now_ms;
          state_d         = mlfq_pkg::ST_LOAD;
        end else begin
          state_d = mlfq_pkg::ST_OUT;
        end
      end
      mlfq_pkg::ST_LOAD: begin
        cur_task_d       = fifo_rd_q;
        cur_valid_d      = 1'b1;
        res_d.dispatched = 1'b1;
        state_d          = mlfq_pkg::ST_OUT;
      end
      mlfq_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = mlfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mlfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mlfq_pkg::ST_IDLE;
      cur_valid_q   <= 1'b0;
      cur_task_q    <= '0;
      slice_start_q <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      state_q       <= state_d;
      cur_valid_q   <= cur_valid_d;
      cur_task_q    <= cur_task_d;
      slice_start_q <= slice_start_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    res_q <= res_d;
    acc_q <= acc_d;
  end

  // running fields come straight from the processor registers
  always_comb begin
    out_data_o               = res_q;
    out_data_o.running_valid = cur_valid_q;
    out_data_o.running_task  = cur_valid_q ? cur_task_q : '0;
  end

endmodule

`default_nettype wire

// ----- design/mlfq_checker.sv -----
// Port-level assertions for the scheduler, bound to the top level.
`default_nettype none

module mlfq_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mlfq_pkg::mlfq_out_t out_data_o
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  // a pending result blocks new input
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_dispatch_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.dispatched |-> out_data_o.running_valid)
    else $error("dispatch without running task");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_valid |-> !out_data_o.demoted && !out_data_o.dropped)
    else $error("completion mixed with demotion or drop");

endmodule

bind multilevel_feedback_task_scheduler_core mlfq_checker u_mlfq_checker (.*);

`default_nettype wire
